// ===== src/dbsw_pkg.sv =====
// ----------------------------------------------------------------------------
// dbsw_pkg
// Shared types and constants of the debounced stopwatch.
// ----------------------------------------------------------------------------
`default_nettype none

package dbsw_pkg;

  localparam int unsigned TICK_W   = 10;  // width of the tick registers
  localparam int unsigned HOLD_W   = 11;  // debounce hold counter
  localparam int unsigned MIN_W    = 7;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned MS_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 32;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(50);
  localparam logic [HOLD_W-1:0] HOLD_MAX      = {HOLD_W{1'b1}};
  localparam logic [TICK_W-1:0] REFRESH_MAX   = {TICK_W{1'b1}};
  localparam logic [MS_W-1:0]   MS_LAST       = MS_W'(999);
  localparam logic [SEC_W-1:0]  SEC_LAST      = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST      = MIN_W'(99);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH  = 1'b1;

  // classified button events of one tick
  typedef struct packed {
    logic a_press;
    logic b_press;
  } evt_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             reset_event;
    logic             paused_event;
    logic             started_event;
    logic             refresh_strobe;
    logic             running;
    logic [MS_W-1:0]  millis;
    logic [SEC_W-1:0] seconds;
    logic [MIN_W-1:0] minutes;
  } result_t;

endpackage

`default_nettype wire

// ===== src/dbsw_debounce.sv =====
// ----------------------------------------------------------------------------
// dbsw_debounce
// Debouncer for one active-low button; flags a newly accepted press.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsw_debounce (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        raw_i,
  input  wire logic [dbsw_pkg::TICK_W-1:0] debounce_ticks_i,
  output logic                             press_o
);

  logic                        last_q, last_d;
  logic                        stable_q, stable_d;
  logic [dbsw_pkg::HOLD_W-1:0] hold_q, hold_d;

  always_comb begin
    press_o  = 1'b0;
    stable_d = stable_q;
    last_d   = raw_i;
    if (raw_i != last_q) begin
      hold_d = '0;
    end else if (hold_q != dbsw_pkg::HOLD_MAX) begin
      hold_d = hold_q + 1'b1;
    end else begin
      hold_d = hold_q;
    end
    if ((hold_d > {1'b0, debounce_ticks_i}) && (raw_i != stable_q)) begin
      stable_d = raw_i;
      press_o  = ~raw_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      hold_q   <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      hold_q   <= hold_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/dbsw_front.sv =====
// ----------------------------------------------------------------------------
// dbsw_front
// Accepts tick beats, debounces both buttons and pushes the press events.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsw_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_valid_i,
  output logic                             tick_ready_o,
  input  wire logic                        button_a_level_i,
  input  wire logic                        button_b_level_i,
  input  wire logic [dbsw_pkg::TICK_W-1:0] debounce_ticks_i,
  input  wire dbsw_pkg::q_stat_t           q_stat_i,
  output logic                             push_o,
  output dbsw_pkg::evt_t                   push_evt_o
);

  logic take;
  logic a_press, b_press;

  assign tick_ready_o = ~q_stat_i.full;
  assign take         = tick_valid_i & ~q_stat_i.full;

  dbsw_debounce u_deb_a (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (take),
    .raw_i            (button_a_level_i),
    .debounce_ticks_i (debounce_ticks_i),
    .press_o          (a_press)
  );

  dbsw_debounce u_deb_b (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (take),
    .raw_i            (button_b_level_i),
    .debounce_ticks_i (debounce_ticks_i),
    .press_o          (b_press)
  );

  assign push_o             = take;
  assign push_evt_o.a_press = a_press;
  assign push_evt_o.b_press = b_press;

endmodule

`default_nettype wire

// ===== src/dbsw_queue.sv =====
// ----------------------------------------------------------------------------
// dbsw_queue
// Small event FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsw_queue #(
  parameter int unsigned Depth = dbsw_pkg::QUEUE_DEPTH  // at least 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dbsw_pkg::evt_t push_evt_i,
  input  wire logic           pop_i,
  output dbsw_pkg::evt_t      head_o,
  output dbsw_pkg::q_stat_t   stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dbsw_pkg::evt_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_evt_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== src/dbsw_back.sv =====
// ----------------------------------------------------------------------------
// dbsw_back
// Run/pause control, time counters and refresh strobe; holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsw_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dbsw_pkg::q_stat_t           q_stat_i,
  input  wire dbsw_pkg::evt_t              head_i,
  output logic                             pop_o,
  input  wire logic [dbsw_pkg::TICK_W-1:0] refresh_ticks_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output dbsw_pkg::result_t                res_o
);

  logic                        run_q, run_d;
  logic [dbsw_pkg::MS_W-1:0]   ms_q, ms_d;
  logic [dbsw_pkg::SEC_W-1:0]  sec_q, sec_d;
  logic [dbsw_pkg::MIN_W-1:0]  min_q, min_d;
  logic [dbsw_pkg::TICK_W-1:0] rfr_q, rfr_d, rfr_inc;
  logic                        out_valid_q;
  dbsw_pkg::result_t           out_q, out_d;
  logic                        at_max;
  logic                        started, paused, cleared, strobe;

  assign pop_o  = ~q_stat_i.empty & (~out_valid_q | res_ready_i);
  assign at_max = (min_q == dbsw_pkg::MIN_LAST) && (sec_q == dbsw_pkg::SEC_LAST) &&
                  (ms_q == dbsw_pkg::MS_LAST);

  always_comb begin
    ms_d    = ms_q;
    sec_d   = sec_q;
    min_d   = min_q;
    run_d   = run_q;
    started = 1'b0;
    paused  = 1'b0;
    cleared = 1'b0;
    strobe  = 1'b0;

    // time advances on the state before this tick's buttons
    if (run_q && !at_max) begin
      if (ms_q == dbsw_pkg::MS_LAST) begin
        ms_d = '0;
        if (sec_q == dbsw_pkg::SEC_LAST) begin
          sec_d = '0;
          min_d = min_q + 1'b1;
        end else begin
          sec_d = sec_q + 1'b1;
        end
      end else begin
        ms_d = ms_q + 1'b1;
      end
    end

    if (head_i.a_press) begin
      run_d   = ~run_q;
      started = ~run_q;
      paused  = run_q;
    end

    // clear only when stopped after A has been handled
    if (head_i.b_press && !run_d) begin
      ms_d    = '0;
      sec_d   = '0;
      min_d   = '0;
      cleared = 1'b1;
    end

    rfr_inc = (rfr_q == dbsw_pkg::REFRESH_MAX) ? rfr_q : rfr_q + 1'b1;
    if (rfr_inc >= refresh_ticks_i) begin
      rfr_d  = '0;
      strobe = 1'b1;
    end else begin
      rfr_d  = rfr_inc;
    end

    out_d.minutes        = min_d;
    out_d.seconds        = sec_d;
    out_d.millis         = ms_d;
    out_d.running        = run_d;
    out_d.refresh_strobe = strobe | cleared;
    out_d.started_event  = started;
    out_d.paused_event   = paused;
    out_d.reset_event    = cleared;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      ms_q        <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      rfr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        run_q <= run_d;
        ms_q  <= ms_d;
        sec_q <= sec_d;
        min_q <= min_d;
        rfr_q <= rfr_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== src/debounced_stopwatch.sv =====
// ----------------------------------------------------------------------------
// debounced_stopwatch
// Debounced start/pause and clear buttons driving an mm:ss:ms stopwatch.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per millisecond tick, carrying the raw active-low
//   levels of the start/pause button and the clear button.
//   Master stream: one result beat per tick with the time after that tick,
//   the running flag, the display refresh strobe and the event flags.
//   Config port: cfg_we_i writes debounce_ticks (index 0) or refresh_ticks
//   (index 1), both reset to 50; the user writes only while the block is idle.
// Path: the edge that takes a tick beat also writes its events into the
//   queue; the counter stage then pops them and loads the output register,
//   which drives m_axis_tvalid.
// Throughput: one beat per cycle while m_axis_tready is high; the counter
//   stage and the output register each take a new tick as the last leaves.
// Reset: buttons read as released, the stopwatch is stopped at 00:00:000,
//   the event queue and the output register are empty and the refresh
//   counter is zero.
// Stall: while m_axis_tready is low the result beat holds, the two-entry
//   event queue fills and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_stopwatch #(
  parameter int unsigned QueueDepth = dbsw_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] button_a_level, [1] button_b_level, [7:2] zero
  input  wire logic [dbsw_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [6:0] minutes, [12:7] seconds, [22:13] millis, [23] running,
  // [24] refresh_strobe, [25] started_event, [26] paused_event,
  // [27] reset_event, [31:28] zero
  output logic [dbsw_pkg::M_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [dbsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dbsw_pkg::TICK_W-1:0]    cfg_data_i
);

  logic [dbsw_pkg::TICK_W-1:0] debounce_q;
  logic [dbsw_pkg::TICK_W-1:0] refresh_q;
  logic                        push, pop;
  dbsw_pkg::evt_t              push_evt, head;
  dbsw_pkg::q_stat_t           q_stat;
  dbsw_pkg::result_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dbsw_pkg::DEFAULT_TICKS;
      refresh_q  <= dbsw_pkg::DEFAULT_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dbsw_pkg::REG_DEBOUNCE: debounce_q <= cfg_data_i;
        dbsw_pkg::REG_REFRESH:  refresh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dbsw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (s_axis_tvalid),
    .tick_ready_o     (s_axis_tready),
    .button_a_level_i (s_axis_tdata[0]),
    .button_b_level_i (s_axis_tdata[1]),
    .debounce_ticks_i (debounce_q),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .push_evt_o       (push_evt)
  );

  dbsw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_evt_i (push_evt),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  dbsw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_stat_i        (q_stat),
    .head_i          (head),
    .pop_o           (pop),
    .refresh_ticks_i (refresh_q),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_o           (res)
  );

  assign m_axis_tdata = {4'b0000, res.reset_event, res.paused_event, res.started_event,
                         res.refresh_strobe, res.running, res.millis, res.seconds,
                         res.minutes};

  // an event never pops from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty event queue");

  // a start leaves the watch running, a pause leaves it stopped
  a_run_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!res.started_event || res.running) &&
                      (!res.paused_event || !res.running))
    else $error("run flag disagrees with start/pause event");

  // a clear only happens while stopped and always refreshes the display
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.reset_event |->
      !res.running && res.refresh_strobe && (res.millis == '0) &&
      (res.seconds == '0) && (res.minutes == '0))
    else $error("bad clear result");

  // time fields stay in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.millis <= dbsw_pkg::MS_LAST) &&
                      (res.seconds <= dbsw_pkg::SEC_LAST) &&
                      (res.minutes <= dbsw_pkg::MIN_LAST))
    else $error("time field out of range");

endmodule

`default_nettype wire
